// ===== src/morse_edge_decoder_assert.svh =====
// Assertion macros shared by the decoder modules.
`ifndef MORSE_EDGE_DECODER_ASSERT_SVH
`define MORSE_EDGE_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MED_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define MED_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/med_pkg.sv =====
// Shared types, codes and the letter table of the Morse edge decoder.
`timescale 1ns / 1ps
package med_pkg;

	localparam int TABLE_LEN  = 29;
	localparam int OUTQ_DEPTH = 4;

	localparam logic [2:0] TREE_TOP = 3'd4;

	localparam logic [1:0] REG_MARK_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_LETTER_GAP     = 2'd1;
	localparam logic [1:0] REG_WORD_GAP       = 2'd2;

	localparam logic [15:0] MARK_THRESHOLD_RST = 16'd200;
	localparam logic [15:0] LETTER_GAP_RST     = 16'd200;
	localparam logic [15:0] WORD_GAP_RST       = 16'd600;

	localparam logic [7:0] CHAR_STAR    = 8'h2A;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

	localparam logic [7:0] LETTER_TABLE [TABLE_LEN] = '{
		"E", "I", "S", "H", "V", "U", "F", "*", "A", "R", "L", "*", "W", "P", "J",
		"T", "N", "D", "B", "X", "K", "C", "Y", "M", "G", "Z", "Q", "O", CHAR_NEWLINE
	};

	typedef struct packed {
		logic [15:0] mark_threshold;
		logic [15:0] letter_gap;
		logic [15:0] word_gap;
	} med_cfg_t;

	// Results of one edge: cnt characters, ch0 first; the last one carries last.
	typedef struct packed {
		logic [1:0] cnt;
		logic [7:0] ch0;
		logic [7:0] ch1;
	} med_push_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} med_entry_t;

	// Tree position zero is an empty letter, otherwise table index plus one.
	function automatic logic [7:0] letter_lookup(input logic [4:0] pos);
		logic [4:0] idx;
		idx = pos - 5'd1;
		if (pos == 5'd0 || pos > 5'(TABLE_LEN))
			return CHAR_STAR;
		return LETTER_TABLE[idx];
	endfunction

endpackage

// ===== src/med_core.sv =====
// Edge timing, tree index accumulation and letter decode.
`timescale 1ns / 1ps
`include "morse_edge_decoder_assert.svh"
module med_core
	import med_pkg::*;
#(
	parameter int MAX_SYMBOLS = 5,
	parameter int TIME_BITS   = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  logic                 level,
	input  logic [TIME_BITS-1:0] now,
	input  med_cfg_t             cfg,
	output med_push_t            push
);

	logic                 have_prev_q;
	logic [TIME_BITS-1:0] prev_time_q;
	logic [4:0]           tree_pos_q;
	logic [2:0]           sym_cnt_q;
	logic                 ovf_q;

	logic [TIME_BITS-1:0] elapsed;
	logic                 dash;
	logic                 letter_hit;
	logic                 word_hit;
	logic                 emit_letter;
	logic [7:0]           letter_ch;
	logic                 sym_full;
	logic [4:0]           tree_step;

	assign elapsed     = now - prev_time_q;
	assign dash        = elapsed > TIME_BITS'(cfg.mark_threshold);
	assign letter_hit  = elapsed > TIME_BITS'(cfg.letter_gap);
	assign word_hit    = elapsed > TIME_BITS'(cfg.word_gap);
	assign emit_letter = letter_hit && (tree_pos_q != 5'd0 || ovf_q);
	assign letter_ch   = ovf_q ? CHAR_STAR : letter_lookup(tree_pos_q);
	assign sym_full    = sym_cnt_q >= 3'(MAX_SYMBOLS);
	assign tree_step   = dash ? (5'd1 << (TREE_TOP - sym_cnt_q)) : 5'd1;

	always_comb begin
		push.cnt = 2'd0;
		push.ch0 = emit_letter ? letter_ch : CHAR_SPACE;
		push.ch1 = CHAR_SPACE;
		if (fire && have_prev_q && level)
			push.cnt = 2'(emit_letter) + 2'(word_hit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			prev_time_q <= '0;
			tree_pos_q  <= 5'd0;
			sym_cnt_q   <= 3'd0;
			ovf_q       <= 1'b0;
		end else if (fire) begin
			have_prev_q <= 1'b1;
			prev_time_q <= now;
			if (have_prev_q) begin
				if (level) begin
					if (letter_hit) begin
						tree_pos_q <= 5'd0;
						sym_cnt_q  <= 3'd0;
						ovf_q      <= 1'b0;
					end
				end else if (sym_full) begin
					ovf_q <= 1'b1;
				end else begin
					tree_pos_q <= tree_pos_q + tree_step;
					sym_cnt_q  <= sym_cnt_q + 3'd1;
				end
			end
		end
	end

	`MED_ASSERT_NOW(a_sym_bound, 1'b1, sym_cnt_q <= 3'(MAX_SYMBOLS), "symbol count past limit")
	`MED_ASSERT_NOW(a_ovf_full, ovf_q, sym_cnt_q == 3'(MAX_SYMBOLS), "overflow before letter full")
	`MED_ASSERT_NOW(a_empty_pos, 1'b1, (sym_cnt_q == 3'd0) == (tree_pos_q == 5'd0),
		"tree position disagrees with symbol count")

endmodule

// ===== src/med_outq.sv =====
// Four-entry output queue taking up to two characters per cycle.
`timescale 1ns / 1ps
`include "morse_edge_decoder_assert.svh"
module med_outq
	import med_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  med_push_t  push,
	output logic       room,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] char_code,
	output logic       last
);

	med_entry_t ent_q [OUTQ_DEPTH];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] count_q;
	logic       pop;

	assign room      = count_q <= 3'(OUTQ_DEPTH - 2);
	assign out_valid = count_q != 3'd0;
	assign pop       = out_valid && !out_stall;
	assign char_code = ent_q[rd_ptr_q].ch;
	assign last      = ent_q[rd_ptr_q].last;

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0)
			ent_q[wr_ptr_q] <= '{ch: push.ch0, last: push.cnt == 2'd1};
		if (push.cnt == 2'd2)
			ent_q[wr_ptr_q + 2'd1] <= '{ch: push.ch1, last: 1'b1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			count_q  <= 3'd0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push.cnt;
			rd_ptr_q <= rd_ptr_q + 2'(pop);
			count_q  <= count_q + 3'(push.cnt) - 3'(pop);
		end
	end

	`MED_ASSERT_NOW(a_cnt_max, 1'b1, count_q <= 3'(OUTQ_DEPTH), "queue count past depth")
	`MED_ASSERT_NOW(a_push_room, push.cnt != 2'd0, room, "push into queue without room")
	`MED_ASSERT_NEXT(a_pop_only, pop && push.cnt == 2'd0, count_q == $past(count_q) - 3'd1,
		"queue count wrong after transfer out")

endmodule

// ===== src/morse_edge_decoder.sv =====
// Morse edge decoder top level: input register, config registers, core and queue.
`timescale 1ns / 1ps
// Accepts one key-line edge per cycle, unless in_stall is high, into an input
// register; the core then times it against the previous edge, updates the
// letter and writes zero to two characters into a four-entry output queue.
// Output drains one character per cycle while out_stall is low; the input
// stalls while the queue has room for fewer than two characters, so the
// sustained rate is one edge per cycle when each edge gives at most one
// character and out_stall is low, and is bounded by the output otherwise.
// Only the low TIME_BITS bits of time_ms are used; elapsed time wraps.
module morse_edge_decoder
	import med_pkg::*;
#(
	parameter int MAX_SYMBOLS = 5,
	parameter int TIME_BITS   = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        new_level,
	input  logic [31:0] time_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  char_code,
	output logic        last
);

	med_cfg_t             cfg_q;
	logic                 valid_s1;
	logic                 level_s1;
	logic [TIME_BITS-1:0] time_s1;
	logic                 room;
	logic                 fire;
	logic                 load;
	med_push_t            push;

	assign fire     = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mark_threshold <= MARK_THRESHOLD_RST;
			cfg_q.letter_gap     <= LETTER_GAP_RST;
			cfg_q.word_gap       <= WORD_GAP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MARK_THRESHOLD: cfg_q.mark_threshold <= cfg_wdata;
				REG_LETTER_GAP:     cfg_q.letter_gap     <= cfg_wdata;
				REG_WORD_GAP:       cfg_q.word_gap       <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (load)
			valid_s1 <= 1'b1;
		else if (fire)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			level_s1 <= new_level;
			time_s1  <= time_ms[TIME_BITS-1:0];
		end
	end

	med_core #(
		.MAX_SYMBOLS(MAX_SYMBOLS),
		.TIME_BITS  (TIME_BITS)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.level (level_s1),
		.now   (time_s1),
		.cfg   (cfg_q),
		.push  (push)
	);

	med_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.char_code(char_code),
		.last     (last)
	);

endmodule

// ===== dv/morse_edge_decoder_tb.sv =====
// Self-checking testbench for morse_edge_decoder: edge stimulus, predicted characters, checks.
`timescale 1ns / 1ps
module morse_edge_decoder_tb;
	import med_pkg::*;

	localparam int           SYMBOL_LIMIT = 5;
	localparam int           LETTER_COUNT = 29;
	localparam logic [8*29-1:0] LETTERS   = "EISHVUF*ARL*WPJTNDBXKCYMGZQO\n";

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} char_entry_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_index = REG_MARK_THRESHOLD;
	logic [15:0] cfg_wdata = '0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic        new_level = 1'b0;
	logic [31:0] time_ms   = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  char_code;
	logic        last;

	// decoder state as the block should hold it
	logic [15:0] cfg_mark   = MARK_THRESHOLD_RST;
	logic [15:0] cfg_letter = LETTER_GAP_RST;
	logic [15:0] cfg_word   = WORD_GAP_RST;
	logic        seen_edge  = 1'b0;
	logic [31:0] last_stamp = '0;
	logic [4:0]  tree_pos   = '0;
	logic [2:0]  sym_count  = '0;
	logic        too_long   = 1'b0;

	char_entry_t char_q[$];
	char_entry_t head;
	logic [31:0] clock_ms      = '0;
	bit          throttle      = 1'b1;
	int          edges_sent    = 0;
	int          chars_checked = 0;
	int          settings_used = 1;
	int          errors        = 0;

	morse_edge_decoder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.new_level (new_level),
		.time_ms   (time_ms),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.char_code (char_code),
		.last      (last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [7:0] current_letter();
		if (too_long || tree_pos == 5'd0 || tree_pos > 5'(LETTER_COUNT))
			return CHAR_STAR;
		return LETTERS[8 * (LETTER_COUNT - int'(tree_pos)) +: 8];
	endfunction

	task automatic predict_edge(input logic lvl, input logic [31:0] stamp);
		logic [31:0] elapsed;
		logic [7:0]  chars[$];
		if (!seen_edge) begin
			seen_edge  = 1'b1;
			last_stamp = stamp;
			return;
		end
		elapsed    = stamp - last_stamp;
		last_stamp = stamp;
		if (lvl) begin
			if (elapsed > {16'd0, cfg_letter}) begin
				if (tree_pos != 5'd0 || too_long)
					chars.push_back(current_letter());
				tree_pos  = '0;
				sym_count = '0;
				too_long  = 1'b0;
			end
			if (elapsed > {16'd0, cfg_word})
				chars.push_back(CHAR_SPACE);
			for (int k = 0; k < chars.size(); k++)
				char_q.push_back('{ch: chars[k], last: (k == chars.size() - 1)});
		end else if (sym_count >= 3'(SYMBOL_LIMIT)) begin
			too_long = 1'b1;
		end else begin
			if (elapsed > {16'd0, cfg_mark})
				tree_pos = tree_pos + (5'd1 << (4 - sym_count));
			else
				tree_pos = tree_pos + 5'd1;
			sym_count = sym_count + 3'd1;
		end
	endtask

	always @(negedge clk)
		out_stall <= throttle && ($urandom_range(99) < 28);

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			chars_checked++;
			if (char_q.size() == 0) begin
				$error("unexpected char transfer: char_code %h last %b", char_code, last);
				errors++;
			end else begin
				head = char_q.pop_front();
				if (char_code !== head.ch) begin
					$error("char_code mismatch: expected %h, got %h", head.ch, char_code);
					errors++;
				end
				if (last !== head.last) begin
					$error("last mismatch: expected %b, got %b", head.last, last);
					errors++;
				end
			end
		end
	end

	task automatic send_edge(input logic lvl, input logic [31:0] stamp);
		while (throttle && $urandom_range(99) < 28) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid  <= 1'b1;
		new_level <= lvl;
		time_ms   <= stamp;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_edge(lvl, stamp);
		edges_sent++;
	endtask

	task automatic step_edge(input logic lvl, input logic [31:0] span);
		clock_ms = clock_ms + span;
		send_edge(lvl, clock_ms);
	endtask

	// drain everything, then give the core time to finish an edge with no output
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (char_q.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MARK_THRESHOLD: cfg_mark   = val;
			REG_LETTER_GAP:     cfg_letter = val;
			REG_WORD_GAP:       cfg_word   = val;
			default: ;
		endcase
	endtask

	task automatic apply_setting(input logic [15:0] mark, input logic [15:0] letter,
			input logic [15:0] word);
		settle();
		write_reg(REG_MARK_THRESHOLD, mark);
		write_reg(REG_LETTER_GAP, letter);
		write_reg(REG_WORD_GAP, word);
		settings_used++;
	endtask

	function automatic logic [31:0] span_upto(input logic [15:0] lim);
		case ($urandom_range(3))
			0:       return {16'd0, lim};
			1:       return 32'd0;
			default: return $urandom_range(lim);
		endcase
	endfunction

	function automatic logic [31:0] span_over(input logic [15:0] lim);
		if ($urandom_range(3) == 0)
			return lim + 32'd1;
		return lim + 32'd1 + $urandom_range(lim + 50);
	endfunction

	function automatic logic [31:0] letter_end_span();
		if (cfg_word > cfg_letter)
			return $urandom_range(cfg_word, cfg_letter + 1);
		return span_over(cfg_letter);
	endfunction

	function automatic logic [31:0] word_end_span();
		return span_over(cfg_word > cfg_letter ? cfg_word : cfg_letter);
	endfunction

	// well-formed letters with random symbols; some run past the symbol limit
	task automatic send_letters(input int count);
		int stop;
		int syms;
		stop = edges_sent + count;
		while (edges_sent < stop) begin
			syms = ($urandom_range(9) == 0) ? $urandom_range(7, 6) : $urandom_range(5, 1);
			for (int k = 0; k < syms; k++) begin
				step_edge(1'b0, $urandom_range(1) ? span_over(cfg_mark) : span_upto(cfg_mark));
				if (k != syms - 1 && $urandom_range(7) != 0)
					step_edge(1'b1, span_upto(cfg_letter));
			end
			case ($urandom_range(9))
				0, 1, 2: step_edge(1'b1, word_end_span());
				3: begin
					step_edge(1'b1, word_end_span());
					step_edge(1'b1, word_end_span());
				end
				default: step_edge(1'b1, letter_end_span());
			endcase
		end
	endtask

	task automatic send_noise(input int count);
		repeat (count) begin
			if ($urandom_range(3) == 0)
				clock_ms = $urandom;
			else
				clock_ms = clock_ms + $urandom_range(2 * cfg_word + 2);
			send_edge(1'($urandom_range(1)), clock_ms);
		end
	endtask

	task automatic test_directed_letters();
		clock_ms = 32'hFFFF_FFFF;
		send_edge(1'b1, clock_ms);
		step_edge(1'b0, 32'd1);
		step_edge(1'b1, 32'd201);
		step_edge(1'b0, 32'd201);
		step_edge(1'b1, 32'd601);
		// dash dash dash dot decodes to newline; gap at the word limit adds no space
		step_edge(1'b0, 32'd500);
		step_edge(1'b0, 32'd201);
		step_edge(1'b0, 32'd65536);
		step_edge(1'b0, 32'd200);
		step_edge(1'b1, 32'd600);
		// four dashes index past the table; maximum elapsed time
		repeat (4) step_edge(1'b0, 32'd201);
		step_edge(1'b1, 32'hFFFF_FFFF);
		// six dots overflow the letter
		repeat (6) step_edge(1'b0, 32'd0);
		step_edge(1'b1, 32'd201);
		// empty letter: gaps give a space only, or nothing
		step_edge(1'b1, 32'd700);
		step_edge(1'b1, 32'd300);
	endtask

	task automatic test_random_letters();
		send_letters(200);
	endtask

	task automatic test_register_settings();
		apply_setting(16'd1, 16'd1, 16'd1);
		send_letters(80);
		send_noise(20);
		apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_letters(80);
		send_noise(20);
		apply_setting(16'd0, 16'd0, 16'd0);
		send_letters(80);
		send_noise(20);
		// word gap below letter gap: spaces without letters
		apply_setting(16'd300, 16'd500, 16'd100);
		send_letters(80);
		send_noise(20);
		apply_setting(16'($urandom_range(16'hFFFF, 1)), 16'($urandom_range(16'hFFFF, 1)),
			16'($urandom_range(16'hFFFF, 1)));
		send_letters(80);
		send_noise(20);
		apply_setting(MARK_THRESHOLD_RST, LETTER_GAP_RST, WORD_GAP_RST);
		send_letters(80);
		send_noise(20);
	endtask

	task automatic test_back_to_back();
		throttle = 1'b0;
		send_letters(100);
		settle();
		throttle = 1'b1;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed_letters();
		test_random_letters();
		test_register_settings();
		test_back_to_back();
		settle();
		repeat (10) @(posedge clk);
		$display("%0d edges under %0d register settings, %0d characters checked", edges_sent,
			settings_used, chars_checked);
		$display("covered letters, overflow, out-of-table, empty letters, time wrap, zero and max gaps");
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
